FILE: src/wsa_pkg.sv
// shared types and constants for the watchpoint slot allocator
// used by wsa_front, wsa_back and watchpoint_slot_allocator
package wsa_pkg;
  localparam int SLOTS      = 4;
  localparam int MAX_CHUNK  = 16;
  localparam int MAX_REGION = 1024;
  localparam int REF_WIDTH  = 16;
  localparam int CTRL_GROUP = 14;
  localparam int STAT_GROUP = 12;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_COUNT  = 2'd2;
  localparam logic [1:0] CMD_REPORT = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] address;
    logic [10:0] length;
    logic [1:0]  rw;
    logic [47:0] hit_status;
  } wsa_cmd_t;
endpackage

FILE: src/wsa_front.sv
// front end: takes commands, saturates length, maps access kind to rw bits
// depends on wsa_pkg; feeds a two-entry queue toward wsa_back
module wsa_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        command,
  input  logic [63:0]       address,
  input  logic [10:0]       length,
  input  logic [1:0]        access_kind,
  input  logic [47:0]       hit_status,
  output logic              q_valid,
  input  logic              q_pop,
  output wsa_pkg::wsa_cmd_t q_data
);
  wsa_pkg::wsa_cmd_t mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  wsa_pkg::wsa_cmd_t item;
  logic push;

  always_comb begin
    item.command    = command;
    item.address    = address;
    item.length     = (length > 11'(wsa_pkg::MAX_REGION)) ? 11'(wsa_pkg::MAX_REGION) : length;
    item.rw         = (access_kind >= 2'd2) ? 2'd3 : access_kind + 2'd1;
    item.hit_status = hit_status;
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= item;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end
endmodule

FILE: src/wsa_back.sv
// back end: walks chunks one per cycle over a shadow copy, then commits it
// if an insert or remove had no failed chunk; depends on wsa_pkg; drives the result register
module wsa_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_pop,
  input  wsa_pkg::wsa_cmd_t q_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              failed,
  output logic [10:0]       chunks_needed,
  output logic              fits,
  output logic              hit,
  output logic [63:0]       hit_address,
  output logic [55:0]       control_image,
  output logic [47:0]       status_image
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state, state_next;

  logic [63:0] addr [wsa_pkg::SLOTS];
  logic [wsa_pkg::REF_WIDTH-1:0] refs [wsa_pkg::SLOTS];
  logic [55:0] ctrl;
  logic [47:0] stat;
  logic [63:0] sh_addr [wsa_pkg::SLOTS];
  logic [wsa_pkg::REF_WIDTH-1:0] sh_refs [wsa_pkg::SLOTS];
  logic [55:0] sh_ctrl;
  logic [47:0] sh_stat;

  logic [1:0]  cmd;
  logic [63:0] cur_a;
  logic [10:0] rem;
  logic [1:0]  rw;
  logic        fail;
  logic [10:0] chunks;

  // chunk size and code for the current step
  logic [4:0]  sz;
  logic [2:0]  lc;
  logic [4:0]  code;
  always_comb begin
    logic [10:0] lim;
    lim = (rem < 11'(wsa_pkg::MAX_CHUNK)) ? rem : 11'(wsa_pkg::MAX_CHUNK);
    sz = 5'd1; lc = 3'd1;
    if (lim >= 11'd2 && cur_a[0] == 1'b0) begin
      sz = 5'd2; lc = 3'd2;
      if (lim >= 11'd4 && cur_a[1] == 1'b0) begin
        sz = 5'd4; lc = 3'd3;
        if (lim >= 11'd8 && cur_a[2] == 1'b0) begin
          sz = 5'd8; lc = 3'd4;
          if (lim >= 11'd16 && cur_a[3] == 1'b0) begin
            sz = 5'd16; lc = 3'd5;
          end
        end
      end
    end
    code = {lc, rw};
  end

  // one chunk against the shadow copy
  logic [63:0] n_addr [wsa_pkg::SLOTS];
  logic [wsa_pkg::REF_WIDTH-1:0] n_refs [wsa_pkg::SLOTS];
  logic [55:0] n_ctrl;
  logic [47:0] n_stat;
  logic        ok;
  always_comb begin
    logic [wsa_pkg::SLOTS-1:0] vld, mt;
    logic       found, vfound;
    logic [1:0] fi, vi;
    found = 1'b0; vfound = 1'b0; fi = '0; vi = '0;
    for (int i = 0; i < wsa_pkg::SLOTS; i++) begin
      n_addr[i] = sh_addr[i];
      n_refs[i] = sh_refs[i];
      vld[i] = sh_ctrl[i*wsa_pkg::CTRL_GROUP] | sh_ctrl[i*wsa_pkg::CTRL_GROUP+12];
      mt[i]  = vld[i] && sh_addr[i] == cur_a
               && sh_ctrl[i*wsa_pkg::CTRL_GROUP+2 +: 5] == code;
    end
    n_ctrl = sh_ctrl;
    n_stat = sh_stat;
    ok = 1'b0;
    for (int i = wsa_pkg::SLOTS-1; i >= 0; i--) begin
      if (mt[i]) begin found = 1'b1; fi = 2'(i); end
      if (!vld[i]) begin vfound = 1'b1; vi = 2'(i); end
    end
    if (cmd == wsa_pkg::CMD_INSERT) begin
      if (found) begin
        ok = 1'b1;
        if (sh_refs[fi] != '1) n_refs[fi] = sh_refs[fi] + 1'b1;
        n_stat[fi*wsa_pkg::STAT_GROUP +: 8] = 8'd0;
      end else if (vfound) begin
        ok = 1'b1;
        n_ctrl[vi*wsa_pkg::CTRL_GROUP +: 13] =
          {1'b1, sh_ctrl[vi*wsa_pkg::CTRL_GROUP+10 +: 2], 3'b111, code, 1'b0, 1'b1};
        n_addr[vi] = cur_a;
        n_refs[vi] = wsa_pkg::REF_WIDTH'(1);
        n_stat[vi*wsa_pkg::STAT_GROUP +: 8] = 8'd0;
      end
    end else begin
      for (int i = 0; i < wsa_pkg::SLOTS; i++) begin
        if (mt[i]) begin
          ok = 1'b1;
          if (sh_refs[i] <= wsa_pkg::REF_WIDTH'(1)) begin
            n_refs[i] = '0;
            n_addr[i] = '0;
            n_ctrl[i*wsa_pkg::CTRL_GROUP]    = 1'b0;
            n_ctrl[i*wsa_pkg::CTRL_GROUP+12] = 1'b0;
          end else begin
            n_refs[i] = sh_refs[i] - 1'b1;
          end
        end
      end
    end
  end

  // report: last hit valid slot
  logic        r_hit;
  logic [63:0] r_addr;
  always_comb begin
    r_hit = 1'b0; r_addr = '0;
    for (int i = 0; i < wsa_pkg::SLOTS; i++) begin
      if ((q_data.hit_status[i*wsa_pkg::STAT_GROUP +: 8] != 8'd0)
          && (ctrl[i*wsa_pkg::CTRL_GROUP] | ctrl[i*wsa_pkg::CTRL_GROUP+12])) begin
        r_hit = 1'b1; r_addr = addr[i];
      end
    end
  end

  logic take;
  logic is_report;
  assign take  = (state == ST_IDLE) && q_valid;
  assign is_report = (q_data.command == wsa_pkg::CMD_REPORT);
  assign q_pop = take;
  assign out_valid = (state == ST_DONE);
  assign control_image = ctrl;
  assign status_image  = stat;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (q_valid) state_next = ST_WALK;
      ST_WALK: if (rem == 11'd0 || fail) state_next = ST_DONE;
      ST_DONE: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ctrl  <= '0;
      stat  <= '0;
      for (int i = 0; i < wsa_pkg::SLOTS; i++) begin
        addr[i] <= '0;
        refs[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (take) begin
        cmd <= q_data.command;
        cur_a <= q_data.address;
        // report has no chunks to walk
        rem <= is_report ? 11'd0 : q_data.length;
        rw <= q_data.rw;
        fail <= 1'b0;
        chunks <= '0;
        failed <= 1'b0;
        fits <= 1'b0;
        hit <= is_report && r_hit;
        hit_address <= is_report ? r_addr : 64'd0;
        chunks_needed <= '0;
        sh_ctrl <= ctrl;
        sh_stat <= stat;
        for (int i = 0; i < wsa_pkg::SLOTS; i++) begin
          sh_addr[i] <= addr[i];
          sh_refs[i] <= refs[i];
        end
        if (is_report) stat <= q_data.hit_status;
      end else if (state == ST_WALK) begin
        if (rem != 11'd0 && !fail) begin
          cur_a <= cur_a + 64'(sz);
          rem <= rem - 11'(sz);
          chunks <= chunks + 11'd1;
          if (cmd == wsa_pkg::CMD_INSERT || cmd == wsa_pkg::CMD_REMOVE) begin
            if (ok) begin
              sh_ctrl <= n_ctrl;
              sh_stat <= n_stat;
              for (int i = 0; i < wsa_pkg::SLOTS; i++) begin
                sh_addr[i] <= n_addr[i];
                sh_refs[i] <= n_refs[i];
              end
            end else begin
              fail <= 1'b1;
            end
          end
        end else begin
          if (cmd == wsa_pkg::CMD_COUNT) begin
            chunks_needed <= chunks;
            fits <= (chunks <= 11'(wsa_pkg::SLOTS));
          end else if (cmd != wsa_pkg::CMD_REPORT) begin
            failed <= fail;
            if (!fail) begin
              ctrl <= sh_ctrl;
              stat <= sh_stat;
              for (int i = 0; i < wsa_pkg::SLOTS; i++) begin
                addr[i] <= sh_addr[i];
                refs[i] <= sh_refs[i];
              end
            end
          end
        end
      end
    end
  end
endmodule

FILE: src/watchpoint_slot_allocator.sv
// top level of the watchpoint slot allocator
// depends on wsa_pkg, wsa_front, wsa_back
//
// channel  direction  handshake
// in       input      in_valid / in_stall
// out      output     out_valid / out_stall
//
// the back end walks one chunk per cycle through its shadow slot copy
// a two-entry queue lets new commands in while a result waits
// rst is synchronous and empties the queue and all slots
module watchpoint_slot_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [63:0] address,
  input  logic [10:0] length,
  input  logic [1:0]  access_kind,
  input  logic [47:0] hit_status,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        failed,
  output logic [10:0] chunks_needed,
  output logic        fits,
  output logic        hit,
  output logic [63:0] hit_address,
  output logic [55:0] control_image,
  output logic [47:0] status_image
);
  logic q_valid, q_pop;
  wsa_pkg::wsa_cmd_t q_data;

  wsa_front u_front (
    .clk, .rst, .in_valid, .in_stall, .command, .address, .length,
    .access_kind, .hit_status, .q_valid, .q_pop, .q_data
  );

  wsa_back u_back (
    .clk, .rst, .q_valid, .q_pop, .q_data, .out_valid, .out_stall,
    .failed, .chunks_needed, .fits, .hit, .hit_address,
    .control_image, .status_image
  );

`ifndef SYNTH
  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_no_pop_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !q_pop) else $error("pop while result pending");
  a_fits_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && fits) |-> (chunks_needed <= 11'd4)) else $error("fits mismatch");
`endif
endmodule

FILE: sim/wsa_checker.sv
// checker for the watchpoint slot allocator: watches both channels,
// predicts each result word from its own slot state and compares field by field
// depends on wsa_pkg
module wsa_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  command,
  input  logic [63:0] address,
  input  logic [10:0] length,
  input  logic [1:0]  access_kind,
  input  logic [47:0] hit_status,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        failed,
  input  logic [10:0] chunks_needed,
  input  logic        fits,
  input  logic        hit,
  input  logic [63:0] hit_address,
  input  logic [55:0] control_image,
  input  logic [47:0] status_image,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        failed;
    logic [10:0] chunks;
    logic        fits;
    logic        hit;
    logic [63:0] haddr;
    logic [55:0] ctrl;
    logic [47:0] stat;
  } wsa_result_t;

  typedef struct {
    logic [63:0] addr [wsa_pkg::SLOTS];
    logic [wsa_pkg::REF_WIDTH-1:0] refs [wsa_pkg::SLOTS];
    logic [55:0] ctrl;
    logic [47:0] stat;
  } slot_bank_t;

  localparam logic [55:0] VALID_PAIR = 56'h1001;
  localparam logic [55:0] CODE_BITS  = 56'h3fe;
  localparam logic [55:0] TAKEN      = 56'h380;
  localparam logic [47:0] HIT_GROUP  = 48'hff;

  slot_bank_t  committed;
  wsa_result_t expected_q [$];

  function automatic bit is_valid(slot_bank_t b, int i);
    return ((b.ctrl >> (wsa_pkg::CTRL_GROUP * i)) & VALID_PAIR) != 0;
  endfunction

  function automatic logic [4:0] code_of(slot_bank_t b, int i);
    return 5'((b.ctrl >> (wsa_pkg::CTRL_GROUP * i + 2)) & 56'h1f);
  endfunction

  function automatic int chunk_len(logic [63:0] a, int rem);
    int lim, s;
    lim = rem < wsa_pkg::MAX_CHUNK ? rem : wsa_pkg::MAX_CHUNK;
    s = 1;
    while (s * 2 <= lim && (a & 64'(s * 2 - 1)) == 0) s = s * 2;
    return s;
  endfunction

  function automatic logic [4:0] chunk_code(int sz, logic [1:0] kind);
    logic [1:0] rw;
    int lc;
    rw = kind >= 2 ? 2'd3 : kind + 2'd1;
    lc = 1;
    while ((1 << (lc - 1)) < sz) lc++;
    return {3'(lc), rw};
  endfunction

  function automatic bit take_chunk(ref slot_bank_t b, input logic [63:0] a,
                                    input logic [4:0] code);
    int i, vac;
    vac = wsa_pkg::SLOTS;
    for (i = 0; i < wsa_pkg::SLOTS; i++) begin
      if (is_valid(b, i)) begin
        if (b.addr[i] == a && code_of(b, i) == code) break;
      end else if (vac == wsa_pkg::SLOTS) begin
        vac = i;
      end
    end
    if (i == wsa_pkg::SLOTS) begin
      if (vac == wsa_pkg::SLOTS) return 0;
      i = vac;
      b.ctrl &= ~(CODE_BITS << (wsa_pkg::CTRL_GROUP * i));
      b.ctrl |= (TAKEN | (56'(code) << 2)) << (wsa_pkg::CTRL_GROUP * i);
      b.ctrl |= VALID_PAIR << (wsa_pkg::CTRL_GROUP * i);
      b.addr[i] = a;
      b.refs[i] = 1;
    end else if (b.refs[i] != '1) begin
      b.refs[i]++;
    end
    b.stat &= ~(HIT_GROUP << (wsa_pkg::STAT_GROUP * i));
    return 1;
  endfunction

  function automatic bit drop_chunk(ref slot_bank_t b, input logic [63:0] a,
                                    input logic [4:0] code);
    bit ok;
    ok = 0;
    for (int i = 0; i < wsa_pkg::SLOTS; i++) begin
      if (is_valid(b, i) && b.addr[i] == a && code_of(b, i) == code) begin
        if (b.refs[i] <= 1) begin
          b.refs[i] = 0;
          b.addr[i] = 0;
          b.ctrl &= ~(VALID_PAIR << (wsa_pkg::CTRL_GROUP * i));
        end else begin
          b.refs[i]--;
        end
        ok = 1;
      end
    end
    return ok;
  endfunction

  function automatic wsa_result_t run_command(logic [1:0] cmd, logic [63:0] a,
                                              logic [10:0] len_in, logic [1:0] kind,
                                              logic [47:0] hs);
    wsa_result_t r;
    slot_bank_t  work;
    int len, sz;
    r = '0;
    len = len_in > wsa_pkg::MAX_REGION ? wsa_pkg::MAX_REGION : int'(len_in);
    case (cmd)
      wsa_pkg::CMD_COUNT: begin
        while (len > 0) begin
          sz = chunk_len(a, len);
          r.chunks++;
          a += 64'(sz);
          len -= sz;
        end
        r.fits = r.chunks <= wsa_pkg::SLOTS;
      end
      wsa_pkg::CMD_REPORT: begin
        committed.stat = hs;
        for (int i = 0; i < wsa_pkg::SLOTS; i++)
          if ((hs & (HIT_GROUP << (wsa_pkg::STAT_GROUP * i))) != 0
              && is_valid(committed, i)) begin
            r.haddr = committed.addr[i];
            r.hit = 1;
          end
      end
      default: begin
        work = committed;
        while (len > 0 && !r.failed) begin
          sz = chunk_len(a, len);
          if (cmd == wsa_pkg::CMD_INSERT)
            r.failed = !take_chunk(work, a, chunk_code(sz, kind));
          else r.failed = !drop_chunk(work, a, chunk_code(sz, kind));
          a += 64'(sz);
          len -= sz;
        end
        if (!r.failed) committed = work;
      end
    endcase
    r.ctrl = committed.ctrl;
    r.stat = committed.stat;
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    wsa_result_t e;
    if (rst) begin
      for (int i = 0; i < wsa_pkg::SLOTS; i++) begin
        committed.addr[i] <= '0;
        committed.refs[i] <= '0;
      end
      committed.ctrl <= '0;
      committed.stat <= '0;
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (in_valid && !in_stall)
        expected_q.push_back(run_command(command, address, length, access_kind, hit_status));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result word with no expectation waiting");
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          if (failed !== e.failed) begin
            $error("failed: expected %0h got %0h", e.failed, failed); fail_count++;
          end
          if (chunks_needed !== e.chunks) begin
            $error("chunks_needed: expected %0d got %0d", e.chunks, chunks_needed);
            fail_count++;
          end
          if (fits !== e.fits) begin
            $error("fits: expected %0h got %0h", e.fits, fits); fail_count++;
          end
          if (hit !== e.hit) begin
            $error("hit: expected %0h got %0h", e.hit, hit); fail_count++;
          end
          if (hit_address !== e.haddr) begin
            $error("hit_address: expected %0h got %0h", e.haddr, hit_address);
            fail_count++;
          end
          if (control_image !== e.ctrl) begin
            $error("control_image: expected %0h got %0h", e.ctrl, control_image);
            fail_count++;
          end
          if (status_image !== e.stat) begin
            $error("status_image: expected %0h got %0h", e.stat, status_image);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

FILE: sim/tb_top.sv
// stimulus and verdict for the watchpoint slot allocator
// depends on wsa_pkg, watchpoint_slot_allocator and wsa_checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;

  logic        clk, rst;
  logic        in_valid, in_stall, out_valid, out_stall;
  logic [1:0]  command, access_kind;
  logic [63:0] address, hit_address;
  logic [10:0] length, chunks_needed;
  logic [47:0] hit_status, status_image;
  logic        failed, fits, hit;
  logic [55:0] control_image;
  int          fail_count, pending, idle_cycles;
  int          words_sent;
  logic [63:0] used_addr [8];

  watchpoint_slot_allocator i_dut (.*);
  wsa_checker i_chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // receiver stall pattern: runs of stall and no-stall of random length
  initial begin
    int run;
    out_stall = 0;
    forever begin
      run = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
      repeat (run) @(posedge clk);
      out_stall <= ($urandom_range(0, 2) == 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchpoint_slot_allocator: mismatch");
      $finish;
    end
  end

  task automatic send_word(logic [1:0] cmd, logic [63:0] a, logic [10:0] len,
                           logic [1:0] kind, logic [47:0] hs);
    in_valid    <= 1;
    command     <= cmd;
    address     <= a;
    length      <= len;
    access_kind <= kind;
    hit_status  <= hs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic pause_sender(int n);
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [10:0] pick_length();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 11'($urandom_range(17, 2047));
    if (r == 1) return 11'd0;
    return 11'($urandom_range(1, 24));
  endfunction

  initial begin
    int burst;
    logic [63:0] a;
    logic [1:0] cmd;
    in_valid = 0; command = 0; address = 0; length = 0;
    access_kind = 0; hit_status = 0; words_sent = 0; rst = 1;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    for (int i = 0; i < 8; i++) used_addr[i] = {$urandom, $urandom} & ~64'hf;
    used_addr[7] = 64'hffff_ffff_ffff_fff8;

    // directed words: extremes, each command, wrap, overfull, saturation of length
    send_word(wsa_pkg::CMD_COUNT, 64'h0, 11'd0, 2'd0, 48'h0);
    send_word(wsa_pkg::CMD_INSERT, 64'h0, 11'd0, 2'd0, 48'h0);
    send_word(wsa_pkg::CMD_REMOVE, 64'h0, 11'd0, 2'd0, 48'h0);
    send_word(wsa_pkg::CMD_COUNT, 64'h3, 11'd2047, 2'd3, '1);
    send_word(wsa_pkg::CMD_COUNT, 64'h1000, 11'd16, 2'd1, 48'h0);
    send_word(wsa_pkg::CMD_INSERT, 64'hffff_ffff_ffff_fffe, 11'd4, 2'd3, 48'h0);
    send_word(wsa_pkg::CMD_REPORT, 64'h0, 11'd0, 2'd0, '1);
    send_word(wsa_pkg::CMD_INSERT, 64'h100, 11'd8, 2'd0, 48'h0);
    send_word(wsa_pkg::CMD_INSERT, 64'h100, 11'd8, 2'd1, 48'h0);
    send_word(wsa_pkg::CMD_INSERT, 64'h200, 11'd64, 2'd2, 48'h0);
    send_word(wsa_pkg::CMD_REPORT, 64'h0, 11'd0, 2'd0, 48'h800_800_800_800);
    send_word(wsa_pkg::CMD_REMOVE, 64'h300, 11'd4, 2'd0, 48'h0);
    send_word(wsa_pkg::CMD_REMOVE, 64'h100, 11'd8, 2'd1, 48'h0);
    send_word(wsa_pkg::CMD_REMOVE, 64'hffff_ffff_ffff_fffe, 11'd4, 2'd2, 48'h0);
    send_word(wsa_pkg::CMD_REMOVE, 64'h100, 11'd8, 2'd0, 48'h0);
    send_word(wsa_pkg::CMD_REPORT, 64'h0, 11'd0, 2'd0, 48'h001_002_004_008);
    send_word(wsa_pkg::CMD_INSERT, 64'hffff_ffff_ffff_ffff, 11'd1, 2'd2, 48'h0);
    send_word(wsa_pkg::CMD_REMOVE, 64'hffff_ffff_ffff_ffff, 11'd1, 2'd2, 48'h0);
    pause_sender(1);
    while (pending != 0) @(posedge clk);

    // random part: mostly insert/remove on a small address pool so slots get reused
    while (words_sent < 1300) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        cmd = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 9) < 7) cmd = 2'($urandom_range(0, 1));
        a = $urandom_range(0, 7) == 0 ? {$urandom, $urandom}
                                      : used_addr[$urandom_range(0, 7)] + 64'($urandom_range(0, 15));
        send_word(cmd, a, pick_length(), 2'($urandom_range(0, 3)),
                  {16'($urandom), $urandom});
      end
      if ($urandom_range(0, 40) == 0) begin
        pause_sender(1);
        while (pending != 0) @(posedge clk);
      end else begin
        pause_sender($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30));
      end
    end
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("sent %0d command words: insert, remove, count and report over",
             words_sent);
    $display("a shared address pool with zero, wrapping and oversized regions");
    if (fail_count == 0) $display("watchpoint_slot_allocator: match");
    else $display("watchpoint_slot_allocator: mismatch");
    $finish;
  end
endmodule
